// ----- rtl/gss_pkg.sv -----
// Shared types, constants and tables for the gas sensor supervisor bar-level block.
`default_nettype none

package gss_pkg;

  // Item geometry
  localparam int unsigned HISTORY_DEPTH = 5;
  localparam int unsigned LEVEL_COUNT   = 9;
  localparam int unsigned READING_W     = 16;
  localparam int unsigned LEVEL_W       = 4;
  localparam int unsigned FILL_W        = $clog2(HISTORY_DEPTH + 1);

  // Register widths
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned INTERVAL_W = 32;
  localparam int unsigned WARM_W     = 8;
  localparam int unsigned INVALID_W  = 4;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [TICK_W-1:0]     TICK_PERIOD_RST     = TICK_W'(5000);
  localparam logic [INTERVAL_W-1:0] REPORT_INTERVAL_RST = INTERVAL_W'(60000);
  localparam logic [WARM_W-1:0]     WARM_UP_RST         = WARM_W'(3);
  localparam logic [INVALID_W-1:0]  INVALID_LIMIT_RST   = INVALID_W'(5);

  // Saturation limit of the invalid counter
  localparam logic [INVALID_W-1:0]  INVALID_MAX = '1;

  // Register indexes of the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TICK_PERIOD     = 2'd0,
    CFG_REPORT_INTERVAL = 2'd1,
    CFG_WARM_UP_REPORTS = 2'd2,
    CFG_INVALID_LIMIT   = 2'd3
  } cfg_reg_t;

  // Bar thresholds in ppm; slots past the ninth can never be exceeded
  localparam logic [READING_W-1:0] THRESHOLDS [16] = '{
    16'd400,   16'd550,   16'd700,   16'd850,   16'd1000,  16'd1333,
    16'd1666,  16'd2000,  16'd2300,  16'd65535, 16'd65535, 16'd65535,
    16'd65535, 16'd65535, 16'd65535, 16'd65535
  };

  // Control from the supervisor to the history
  typedef struct packed {
    logic push;
    logic clear;
  } hist_ctrl_t;

  // One result transaction
  typedef struct packed {
    logic                 report;
    logic [READING_W-1:0] report_value;
    logic                 restart;
    logic [LEVEL_W-1:0]   bar_level;
    logic                 bar_update;
  } gss_result_t;

endpackage

`default_nettype wire

// ----- rtl/gss_history.sv -----
// Reading history with fill count and stuck-reading detection.
`default_nettype none

module gss_history (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire gss_pkg::hist_ctrl_t           ctrl,
  input  wire [gss_pkg::READING_W-1:0]       value,
  output logic                               stuck
);

  logic [gss_pkg::READING_W-1:0] hist_r   [gss_pkg::HISTORY_DEPTH];
  logic [gss_pkg::READING_W-1:0] hist_nxt [gss_pkg::HISTORY_DEPTH];
  logic [gss_pkg::FILL_W-1:0]    fill_r;
  logic [gss_pkg::FILL_W-1:0]    fill_nxt;
  logic                          full;
  logic [gss_pkg::HISTORY_DEPTH-1:0] same;

  assign full = (fill_r == gss_pkg::FILL_W'(gss_pkg::HISTORY_DEPTH));

  // Fill the next free slot, or shift out the oldest once full
  for (genvar i = 0; i < gss_pkg::HISTORY_DEPTH; i++) begin : g_ent
    logic [gss_pkg::READING_W-1:0] shifted;
    if (i < gss_pkg::HISTORY_DEPTH - 1) begin : g_mid
      assign shifted = hist_r[i+1];
    end else begin : g_last
      assign shifted = value;
    end
    always_comb begin
      hist_nxt[i] = hist_r[i];
      if (ctrl.push) begin
        if (full) begin
          hist_nxt[i] = shifted;
        end else if (fill_r == gss_pkg::FILL_W'(i)) begin
          hist_nxt[i] = value;
        end
      end
    end
    assign same[i] = (hist_nxt[i] == hist_nxt[0]);
  end

  assign fill_nxt = (ctrl.push && !full) ? fill_r + 1'b1 : fill_r;

  // Stuck when the history after this push is full of equal readings
  assign stuck = (fill_nxt == gss_pkg::FILL_W'(gss_pkg::HISTORY_DEPTH)) && (&same);

  // Hold the fill count; a restart empties the history
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Store entries on a push
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      hist_r <= hist_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gss_level.sv -----
// Bar level: count of thresholds the reading strictly exceeds.
`default_nettype none

module gss_level (
  input  wire  [gss_pkg::READING_W-1:0] reading,
  output logic [gss_pkg::LEVEL_W-1:0]   level
);

  logic [gss_pkg::LEVEL_COUNT-1:0] hit;

  // Compare against every threshold in parallel
  for (genvar i = 0; i < gss_pkg::LEVEL_COUNT; i++) begin : g_cmp
    assign hit[i] = (reading > gss_pkg::THRESHOLDS[i]);
  end

  assign level = gss_pkg::LEVEL_W'($countones(hit));

endmodule

`default_nettype wire

// ----- rtl/gas_sensor_supervisor_bar_level.sv -----
// Top level of the gas sensor supervisor: timing, reporting, restart and bar level.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   in      | input     | in_valid / in_stall   | in_co2_reading
//   out     | output    | out_valid / out_stall | out_report, out_report_value, out_restart,
//           |           |                      | out_bar_level, out_bar_update
//   cfg     | input     | cfg_we               | cfg_addr, cfg_wdata
//
// One transaction per cycle while in_stall is low: the whole update is a single
// pass from the state registers to the result register, or to the skid entry.
// A result register plus one skid entry sit on the output; in_stall rises only
// when the skid entry is occupied.
// Reset is synchronous, active low, and loads register defaults and clears state.
`default_nettype none

module gas_sensor_supervisor_bar_level (
  input  wire                               clk,
  input  wire                               rst_n,
  // input channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [gss_pkg::READING_W-1:0]     in_co2_reading,
  // result channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              out_report,
  output logic [gss_pkg::READING_W-1:0]     out_report_value,
  output logic                              out_restart,
  output logic [gss_pkg::LEVEL_W-1:0]       out_bar_level,
  output logic                              out_bar_update,
  // configuration
  input  wire                               cfg_we,
  input  wire  [gss_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire  [gss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // Configuration registers
  logic [gss_pkg::TICK_W-1:0]     tick_period_r;
  logic [gss_pkg::INTERVAL_W-1:0] report_interval_r;
  logic [gss_pkg::WARM_W-1:0]     warm_up_reports_r;
  logic [gss_pkg::INVALID_W-1:0]  invalid_limit_r;

  // Supervisor state
  logic [gss_pkg::INTERVAL_W-1:0] elapsed_ms_r, elapsed_ms_nxt;
  logic [gss_pkg::WARM_W-1:0]     warm_up_left_r, warm_up_left_nxt;
  logic [gss_pkg::INVALID_W-1:0]  invalid_count_r, invalid_count_nxt;
  logic [gss_pkg::LEVEL_W-1:0]    shown_level_r;
  logic                           shown_valid_r;

  // Output register and skid entry
  gss_pkg::gss_result_t out_r, skid_r, result;
  logic                 out_valid_r, skid_valid_r;

  logic                           accept;
  logic                           out_take;
  logic [gss_pkg::INTERVAL_W:0]   elapsed_sum;
  logic [gss_pkg::INTERVAL_W-1:0] elapsed_sat;
  logic                           step;
  logic                           report_c;
  logic                           restart_c;
  logic                           stuck;
  logic [gss_pkg::LEVEL_W-1:0]    level;
  logic                           update_c;
  gss_pkg::hist_ctrl_t            hist_ctrl;

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  // Advance elapsed time, saturating at all ones
  assign elapsed_sum = {1'b0, elapsed_ms_r} + {{(gss_pkg::INTERVAL_W + 1 - gss_pkg::TICK_W){1'b0}},
                                               tick_period_r};
  assign elapsed_sat = elapsed_sum[gss_pkg::INTERVAL_W] ? '1
                                                       : elapsed_sum[gss_pkg::INTERVAL_W-1:0];
  assign step        = (elapsed_sat > report_interval_r);

  // Report step: invalid counting, warm-up and report decision
  always_comb begin
    elapsed_ms_nxt    = elapsed_sat;
    invalid_count_nxt = invalid_count_r;
    warm_up_left_nxt  = warm_up_left_r;
    report_c          = 1'b0;
    if (step) begin
      elapsed_ms_nxt = '0;
      if (in_co2_reading == '0) begin
        if (invalid_count_r != gss_pkg::INVALID_MAX) begin
          invalid_count_nxt = invalid_count_r + 1'b1;
        end
      end else begin
        invalid_count_nxt = '0;
      end
      if (warm_up_left_r == '0) begin
        report_c = 1'b1;
      end else begin
        warm_up_left_nxt = warm_up_left_r - 1'b1;
      end
    end
  end

  assign hist_ctrl.push  = accept && step;
  assign hist_ctrl.clear = accept && restart_c;

  gss_history u_history (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (hist_ctrl),
    .value (in_co2_reading),
    .stuck (stuck)
  );

  gss_level u_level (
    .reading (in_co2_reading),
    .level   (level)
  );

  // Restart decision and bar update
  assign restart_c = (invalid_count_nxt > invalid_limit_r) || stuck;
  assign update_c  = !restart_c && (!shown_valid_r || (shown_level_r != level));

  always_comb begin
    result.report       = report_c;
    result.report_value = in_co2_reading;
    result.restart      = restart_c;
    result.bar_level    = restart_c ? '0 : level;
    result.bar_update   = update_c;
  end

  // Configuration writes and supervisor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r     <= gss_pkg::TICK_PERIOD_RST;
      report_interval_r <= gss_pkg::REPORT_INTERVAL_RST;
      warm_up_reports_r <= gss_pkg::WARM_UP_RST;
      invalid_limit_r   <= gss_pkg::INVALID_LIMIT_RST;
      elapsed_ms_r      <= '0;
      warm_up_left_r    <= gss_pkg::WARM_UP_RST;
      invalid_count_r   <= '0;
      shown_level_r     <= '0;
      shown_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (gss_pkg::cfg_reg_t'(cfg_addr))
          gss_pkg::CFG_TICK_PERIOD:     tick_period_r     <= cfg_wdata[gss_pkg::TICK_W-1:0];
          gss_pkg::CFG_REPORT_INTERVAL: report_interval_r <= cfg_wdata[gss_pkg::INTERVAL_W-1:0];
          gss_pkg::CFG_WARM_UP_REPORTS: warm_up_reports_r <= cfg_wdata[gss_pkg::WARM_W-1:0];
          gss_pkg::CFG_INVALID_LIMIT:   invalid_limit_r   <= cfg_wdata[gss_pkg::INVALID_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (restart_c) begin
          elapsed_ms_r    <= '0;
          warm_up_left_r  <= warm_up_reports_r;
          invalid_count_r <= '0;
          shown_level_r   <= '0;
          shown_valid_r   <= 1'b0;
        end else begin
          elapsed_ms_r    <= elapsed_ms_nxt;
          warm_up_left_r  <= warm_up_left_nxt;
          invalid_count_r <= invalid_count_nxt;
          if (update_c) begin
            shown_level_r <= level;
            shown_valid_r <= 1'b1;
          end
        end
      end
    end
  end

  // Output valid flags: result register first, skid entry when it is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_take) begin
          skid_valid_r <= 1'b0;
        end
      end else if (accept) begin
        if (out_valid_r && !out_take) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload: load from skid on drain, otherwise from the new result
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (out_valid_r && !out_take) begin
        skid_r <= result;
      end else begin
        out_r <= result;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_report       = out_r.report;
  assign out_report_value = out_r.report_value;
  assign out_restart      = out_r.restart;
  assign out_bar_level    = out_r.bar_level;
  assign out_bar_update   = out_r.bar_update;

`ifndef SYNTH
  // A restart result carries no bar level and no update
  a_restart_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_restart |-> out_bar_level == '0 && !out_bar_update)
    else $error("restart result carries a bar level or update");

  // The skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty result register");

  // An accepted restart clears the supervisor state
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && restart_c |=> elapsed_ms_r == '0 && invalid_count_r == '0 && !shown_valid_r
                            && warm_up_left_r == warm_up_reports_r)
    else $error("state not cleared after restart");

  // Bar level never exceeds the threshold count
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bar_level <= gss_pkg::LEVEL_W'(gss_pkg::LEVEL_COUNT))
    else $error("bar level out of range");

  // An update always records the shown level
  a_update_records: assert property (@(posedge clk) disable iff (!rst_n)
    accept && update_c |=> shown_valid_r && shown_level_r == $past(level))
    else $error("shown level not recorded on update");
`endif

endmodule

`default_nettype wire
